/* sv/bstc_pkg.sv */
`timescale 1ns / 1ps

package bstc_pkg;

   // operation codes
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ADJUST = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // adjust step codes
   localparam logic [2:0] STEP_HOUR  = 3'd0;
   localparam logic [2:0] STEP_MIN1  = 3'd1;
   localparam logic [2:0] STEP_MIN5  = 3'd2;
   localparam logic [2:0] STEP_MIN10 = 3'd3;
   localparam logic [2:0] STEP_MIN30 = 3'd4;

   // decimal point masks
   localparam logic [2:0] DOT_HIGH = 3'b100;
   localparam logic [2:0] DOT_MID  = 3'b010;
   localparam logic [2:0] DOT_OFF  = 3'b000;

   localparam logic [3:0] DIGIT_MAX  = 4'd9;
   localparam logic [2:0] TENS_MAX   = 3'd5;
   localparam logic [3:0] BLINK_FROM = 4'd5;

   typedef struct packed {
      logic [3:0] hour;
      logic [2:0] min_tens;
      logic [3:0] min_ones;
      logic [2:0] sec_tens;
      logic [3:0] sec_ones;
      logic [3:0] tenth;
   } time_type;

   typedef struct packed {
      logic [3:0] lo;
      logic [3:0] mid;
      logic [3:0] hi;
      logic [2:0] dots;
   } disp_type;

endpackage

/* sv/bstc_step.sv */
`timescale 1ns / 1ps

module bstc_step (
   input  bstc_pkg::time_type cur,
   input  logic [1:0]         operation,
   input  logic               direction,
   input  logic [2:0]         step_size,
   output bstc_pkg::time_type nxt,
   output logic               limit_hit,
   output bstc_pkg::disp_type disp
);

   bstc_pkg::time_type tick_t;
   bstc_pkg::time_type adj_t;
   logic               tick_hit;
   logic               adj_hit;
   logic               all_max;
   logic               all_zero;
   logic               c1, c2, c3, c4, c5;

   logic [3:0] ones_add;
   logic [2:0] tens_add;
   logic       min_step;
   logic [4:0] ones_sum;
   logic       ones_c;
   logic [3:0] tens_sum;
   logic       tens_c;
   logic [4:0] hour_sum;

   always_comb begin
      all_max  = cur.hour == bstc_pkg::DIGIT_MAX && cur.min_tens == bstc_pkg::TENS_MAX &&
                 cur.min_ones == bstc_pkg::DIGIT_MAX && cur.sec_tens == bstc_pkg::TENS_MAX &&
                 cur.sec_ones == bstc_pkg::DIGIT_MAX && cur.tenth == bstc_pkg::DIGIT_MAX;
      all_zero = cur == '0;
      tick_t   = cur;
      tick_hit = 1'b0;
      c1 = 1'b0; c2 = 1'b0; c3 = 1'b0; c4 = 1'b0; c5 = 1'b0;
      if (!direction) begin
         if (all_max) begin
            tick_hit = 1'b1;
         end else begin
            c1 = cur.tenth == bstc_pkg::DIGIT_MAX;
            c2 = c1 && cur.sec_ones == bstc_pkg::DIGIT_MAX;
            c3 = c2 && cur.sec_tens == bstc_pkg::TENS_MAX;
            c4 = c3 && cur.min_ones == bstc_pkg::DIGIT_MAX;
            c5 = c4 && cur.min_tens == bstc_pkg::TENS_MAX;
            tick_t.tenth = c1 ? 4'd0 : cur.tenth + 4'd1;
            if (c1) tick_t.sec_ones = c2 ? 4'd0 : cur.sec_ones + 4'd1;
            if (c2) tick_t.sec_tens = c3 ? 3'd0 : cur.sec_tens + 3'd1;
            if (c3) tick_t.min_ones = c4 ? 4'd0 : cur.min_ones + 4'd1;
            if (c4) tick_t.min_tens = c5 ? 3'd0 : cur.min_tens + 3'd1;
            if (c5) tick_t.hour     = cur.hour + 4'd1;
         end
      end else begin
         if (all_zero) begin
            tick_hit = 1'b1;
         end else begin
            // borrow chain
            c1 = cur.tenth == 4'd0;
            c2 = c1 && cur.sec_ones == 4'd0;
            c3 = c2 && cur.sec_tens == 3'd0;
            c4 = c3 && cur.min_ones == 4'd0;
            c5 = c4 && cur.min_tens == 3'd0;
            tick_t.tenth = c1 ? bstc_pkg::DIGIT_MAX : cur.tenth - 4'd1;
            if (c1) tick_t.sec_ones = c2 ? bstc_pkg::DIGIT_MAX : cur.sec_ones - 4'd1;
            if (c2) tick_t.sec_tens = c3 ? bstc_pkg::TENS_MAX : cur.sec_tens - 3'd1;
            if (c3) tick_t.min_ones = c4 ? bstc_pkg::DIGIT_MAX : cur.min_ones - 4'd1;
            if (c4) tick_t.min_tens = c5 ? bstc_pkg::TENS_MAX : cur.min_tens - 3'd1;
            if (c5) tick_t.hour     = cur.hour - 4'd1;
         end
      end
   end

   always_comb begin
      ones_add = 4'd0;
      tens_add = 3'd0;
      min_step = 1'b1;
      unique case (step_size)
         bstc_pkg::STEP_MIN1:  ones_add = 4'd1;
         bstc_pkg::STEP_MIN5:  ones_add = 4'd5;
         bstc_pkg::STEP_MIN10: tens_add = 3'd1;
         bstc_pkg::STEP_MIN30: tens_add = 3'd3;
         default:              min_step = 1'b0;
      endcase

      adj_t          = cur;
      adj_t.sec_tens = 3'd0;
      adj_t.sec_ones = 4'd0;
      adj_t.tenth    = 4'd0;
      adj_hit        = 1'b0;
      ones_sum       = '0;
      ones_c         = 1'b0;
      tens_sum       = '0;
      tens_c         = 1'b0;
      hour_sum       = '0;

      if (step_size == bstc_pkg::STEP_HOUR) begin
         if (!direction) begin
            if (cur.hour >= bstc_pkg::DIGIT_MAX) adj_hit = 1'b1;
            else                                adj_t.hour = cur.hour + 4'd1;
         end else begin
            if (cur.hour == 4'd0) adj_hit = 1'b1;
            else                  adj_t.hour = cur.hour - 4'd1;
         end
      end else if (min_step) begin
         if (!direction) begin
            ones_sum = {1'b0, cur.min_ones} + {1'b0, ones_add};
            ones_c   = ones_sum >= 5'd10;
            tens_sum = {1'b0, cur.min_tens} + {1'b0, tens_add} + {3'd0, ones_c};
            tens_c   = tens_sum >= 4'd6;
            hour_sum = {1'b0, cur.hour} + {4'd0, tens_c};
            if (hour_sum > {1'b0, bstc_pkg::DIGIT_MAX}) begin
               adj_hit        = 1'b1;
               adj_t.hour     = bstc_pkg::DIGIT_MAX;
               adj_t.min_tens = bstc_pkg::TENS_MAX;
               adj_t.min_ones = bstc_pkg::DIGIT_MAX;
            end else begin
               adj_t.hour     = hour_sum[3:0];
               adj_t.min_tens = tens_c ? 3'(tens_sum - 4'd6) : tens_sum[2:0];
               adj_t.min_ones = ones_c ? 4'(ones_sum - 5'd10) : ones_sum[3:0];
            end
         end else begin
            // top bit of each difference is the borrow
            ones_sum = {1'b0, cur.min_ones} - {1'b0, ones_add};
            ones_c   = ones_sum[4];
            tens_sum = {1'b0, cur.min_tens} - {1'b0, tens_add} - {3'd0, ones_c};
            tens_c   = tens_sum[3];
            hour_sum = {1'b0, cur.hour} - {4'd0, tens_c};
            if (hour_sum[4]) begin
               adj_hit        = 1'b1;
               adj_t.hour     = 4'd0;
               adj_t.min_tens = 3'd0;
               adj_t.min_ones = 4'd0;
            end else begin
               adj_t.hour     = hour_sum[3:0];
               adj_t.min_tens = tens_c ? 3'(tens_sum + 4'd6) : tens_sum[2:0];
               adj_t.min_ones = ones_c ? 4'(ones_sum + 5'd10) : ones_sum[3:0];
            end
         end
      end
   end

   always_comb begin
      nxt       = cur;
      limit_hit = 1'b0;
      unique case (operation)
         bstc_pkg::OP_TICK: begin
            nxt       = tick_t;
            limit_hit = tick_hit;
         end
         bstc_pkg::OP_ADJUST: begin
            nxt       = adj_t;
            limit_hit = adj_hit;
         end
         bstc_pkg::OP_CLEAR: nxt = '0;
         default: ;
      endcase

      if (nxt.hour != 4'd0 || nxt.min_tens != 3'd0) begin
         disp.lo   = nxt.min_ones;
         disp.mid  = {1'b0, nxt.min_tens};
         disp.hi   = nxt.hour;
         disp.dots = bstc_pkg::DOT_HIGH;
      end else if (nxt.min_ones != 4'd0) begin
         disp.lo   = nxt.sec_ones;
         disp.mid  = {1'b0, nxt.sec_tens};
         disp.hi   = nxt.min_ones;
         disp.dots = bstc_pkg::DOT_HIGH;
      end else begin
         disp.lo   = nxt.tenth;
         disp.mid  = nxt.sec_ones;
         disp.hi   = {1'b0, nxt.sec_tens};
         disp.dots = bstc_pkg::DOT_MID;
      end
      // blink phase
      if (nxt.tenth >= bstc_pkg::BLINK_FROM) disp.dots = bstc_pkg::DOT_OFF;
   end

endmodule

/* sv/bcd_saturating_time_counter.sv */
`timescale 1ns / 1ps
// A transaction accepted into the input register passes through the step logic into the result
// register and appears on rsp_; a stall on the result side holds it in the input register.
// Throughput: one transaction per cycle while the result side does not stall; the digit update
// is one pass of logic between the input register and the result register.
// Reset (synchronous, active high) zeroes all six digits and empties both registers.

module bcd_saturating_time_counter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic       req_direction,
   input  logic [2:0] req_step_size,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_limit_hit,
   output logic [3:0] rsp_shown_digit_low,
   output logic [3:0] rsp_shown_digit_mid,
   output logic [3:0] rsp_shown_digit_high,
   output logic [2:0] rsp_dot_mask,
   output logic [3:0] rsp_hours_now,
   output logic [2:0] rsp_minute_tens_now,
   output logic [3:0] rsp_minute_ones_now,
   output logic [2:0] rsp_second_tens_now,
   output logic [3:0] rsp_second_ones_now,
   output logic [3:0] rsp_tenths_now
);

   logic               in_valid_ff, in_valid_in;
   logic [1:0]         in_op_ff;
   logic               in_dir_ff;
   logic [2:0]         in_step_ff;
   bstc_pkg::time_type time_ff, time_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_hit_ff;
   bstc_pkg::disp_type out_disp_ff;
   bstc_pkg::time_type out_time_ff;

   logic               advance;
   logic               req_take;
   logic               step_hit;
   bstc_pkg::disp_type step_disp;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   bstc_step u_step (
      .cur       (time_ff),
      .operation (in_op_ff),
      .direction (in_dir_ff),
      .step_size (in_step_ff),
      .nxt       (time_in),
      .limit_hit (step_hit),
      .disp      (step_disp)
   );

   always_comb begin
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else              in_valid_in = in_valid_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         time_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance && in_valid_ff) time_ff <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_operation;
         in_dir_ff  <= req_direction;
         in_step_ff <= req_step_size;
      end
      if (advance && in_valid_ff) begin
         out_hit_ff  <= step_hit;
         out_disp_ff <= step_disp;
         out_time_ff <= time_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_limit_hit        = out_hit_ff;
   assign rsp_shown_digit_low  = out_disp_ff.lo;
   assign rsp_shown_digit_mid  = out_disp_ff.mid;
   assign rsp_shown_digit_high = out_disp_ff.hi;
   assign rsp_dot_mask         = out_disp_ff.dots;
   assign rsp_hours_now        = out_time_ff.hour;
   assign rsp_minute_tens_now  = out_time_ff.min_tens;
   assign rsp_minute_ones_now  = out_time_ff.min_ones;
   assign rsp_second_tens_now  = out_time_ff.sec_tens;
   assign rsp_second_ones_now  = out_time_ff.sec_ones;
   assign rsp_tenths_now       = out_time_ff.tenth;

endmodule

/* sv/bstc_checker.sv */
`timescale 1ns / 1ps

module bstc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_shown_digit_low,
   input logic [2:0] rsp_dot_mask,
   input logic [3:0] rsp_hours_now,
   input logic [2:0] rsp_minute_tens_now,
   input logic [3:0] rsp_minute_ones_now,
   input logic [2:0] rsp_second_tens_now,
   input logic [3:0] rsp_second_ones_now,
   input logic [3:0] rsp_tenths_now
);

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // an empty result register never holds off the request side
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with no result pending");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hours_now) &&
         $stable(rsp_tenths_now) && $stable(rsp_dot_mask))
      else $error("stalled transaction changed");

   a_digits_bcd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hours_now <= 4'd9 && rsp_minute_tens_now <= 3'd5 &&
         rsp_minute_ones_now <= 4'd9 && rsp_second_tens_now <= 3'd5 &&
         rsp_second_ones_now <= 4'd9 && rsp_tenths_now <= 4'd9)
      else $error("digit out of range");

   // seconds view only when hours and minutes are all zero, showing the tenths
   a_seconds_view: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dot_mask == 3'b010 |-> rsp_hours_now == 4'd0 &&
         rsp_minute_tens_now == 3'd0 && rsp_minute_ones_now == 4'd0 &&
         rsp_shown_digit_low == rsp_tenths_now)
      else $error("seconds view shown with nonzero minutes");

endmodule

bind bcd_saturating_time_counter bstc_checker u_bstc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_shown_digit_low (rsp_shown_digit_low),
   .rsp_dot_mask        (rsp_dot_mask),
   .rsp_hours_now       (rsp_hours_now),
   .rsp_minute_tens_now (rsp_minute_tens_now),
   .rsp_minute_ones_now (rsp_minute_ones_now),
   .rsp_second_tens_now (rsp_second_tens_now),
   .rsp_second_ones_now (rsp_second_ones_now),
   .rsp_tenths_now      (rsp_tenths_now)
);

/* verif/bcd_saturating_time_counter_tb.sv */
`timescale 1ns / 1ps

module bcd_saturating_time_counter_tb;

   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam logic [2:0] STEP_SPARE_LO  = 3'd5;
   localparam logic [2:0] STEP_SPARE_HI  = 3'd7;
   localparam logic       DIR_UP         = 1'b0;
   localparam logic       DIR_DOWN       = 1'b1;
   localparam int         MINUTES_CEIL   = 599;
   localparam int         TENTHS_CEIL    = 359999;
   localparam int         WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic               limit_hit;
      bstc_pkg::disp_type shown;
      bstc_pkg::time_type digits;
   } display_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_operation = bstc_pkg::OP_TICK;
   logic       req_direction = DIR_UP;
   logic [2:0] req_step_size = bstc_pkg::STEP_HOUR;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_limit_hit;
   logic [3:0] rsp_shown_digit_low;
   logic [3:0] rsp_shown_digit_mid;
   logic [3:0] rsp_shown_digit_high;
   logic [2:0] rsp_dot_mask;
   logic [3:0] rsp_hours_now;
   logic [2:0] rsp_minute_tens_now;
   logic [3:0] rsp_minute_ones_now;
   logic [2:0] rsp_second_tens_now;
   logic [3:0] rsp_second_ones_now;
   logic [3:0] rsp_tenths_now;

   bstc_pkg::time_type clock_digits = '0;
   display_result_type expected_displays[$];
   int                 error_count = 0;
   int                 commands_sent = 0;
   int                 quiet_cycles = 0;
   int                 stall_left = 0;
   logic               idle_en = 1'b1;

   bcd_saturating_time_counter dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_direction        (req_direction),
      .req_step_size        (req_step_size),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_limit_hit        (rsp_limit_hit),
      .rsp_shown_digit_low  (rsp_shown_digit_low),
      .rsp_shown_digit_mid  (rsp_shown_digit_mid),
      .rsp_shown_digit_high (rsp_shown_digit_high),
      .rsp_dot_mask         (rsp_dot_mask),
      .rsp_hours_now        (rsp_hours_now),
      .rsp_minute_tens_now  (rsp_minute_tens_now),
      .rsp_minute_ones_now  (rsp_minute_ones_now),
      .rsp_second_tens_now  (rsp_second_tens_now),
      .rsp_second_ones_now  (rsp_second_ones_now),
      .rsp_tenths_now       (rsp_tenths_now)
   );

   always #5 clock = ~clock;

   // ---------------- time arithmetic ----------------

   function automatic int minutes_of(bstc_pkg::time_type t);
      return t.hour * 60 + t.min_tens * 10 + t.min_ones;
   endfunction

   function automatic int tenths_of(bstc_pkg::time_type t);
      return ((minutes_of(t) * 60 + t.sec_tens * 10 + t.sec_ones) * 10) + t.tenth;
   endfunction

   function automatic bstc_pkg::time_type time_from_tenths(int v);
      bstc_pkg::time_type t;
      int                 secs;
      int                 mins;
      secs       = v / 10;
      mins       = secs / 60;
      t.tenth    = 4'(v % 10);
      t.sec_ones = 4'(secs % 10);
      t.sec_tens = 3'((secs % 60) / 10);
      t.hour     = 4'(mins / 60);
      t.min_tens = 3'((mins % 60) / 10);
      t.min_ones = 4'(mins % 10);
      return t;
   endfunction

   function automatic int step_minutes(logic [2:0] step);
      case (step)
         bstc_pkg::STEP_MIN1:  return 1;
         bstc_pkg::STEP_MIN5:  return 5;
         bstc_pkg::STEP_MIN10: return 10;
         bstc_pkg::STEP_MIN30: return 30;
         default:              return 0;
      endcase
   endfunction

   function automatic bstc_pkg::disp_type display_of(bstc_pkg::time_type t);
      bstc_pkg::disp_type d;
      if (t.hour != 0 || t.min_tens != 0) begin
         d = '{lo: t.min_ones, mid: {1'b0, t.min_tens}, hi: t.hour,
               dots: bstc_pkg::DOT_HIGH};
      end else if (t.min_ones != 0) begin
         d = '{lo: t.sec_ones, mid: {1'b0, t.sec_tens}, hi: t.min_ones,
               dots: bstc_pkg::DOT_HIGH};
      end else begin
         d = '{lo: t.tenth, mid: t.sec_ones, hi: {1'b0, t.sec_tens},
               dots: bstc_pkg::DOT_MID};
      end
      if (t.tenth >= bstc_pkg::BLINK_FROM)
         d.dots = bstc_pkg::DOT_OFF;
      return d;
   endfunction

   // advance the predicted clock by one command and queue the display it should produce
   task automatic predict_display(logic [1:0] op, logic dir, logic [2:0] step);
      display_result_type r;
      int                 v;
      int                 n;
      int                 m;
      r.limit_hit = 1'b0;
      case (op)
         bstc_pkg::OP_TICK: begin
            v = tenths_of(clock_digits);
            if (dir == DIR_DOWN) begin
               if (v == 0) r.limit_hit = 1'b1;
               else clock_digits = time_from_tenths(v - 1);
            end else begin
               if (v >= TENTHS_CEIL) r.limit_hit = 1'b1;
               else clock_digits = time_from_tenths(v + 1);
            end
         end
         bstc_pkg::OP_ADJUST: begin
            clock_digits.sec_tens = '0;
            clock_digits.sec_ones = '0;
            clock_digits.tenth    = '0;
            if (step == bstc_pkg::STEP_HOUR) begin
               if (dir == DIR_DOWN) begin
                  if (clock_digits.hour == 0) r.limit_hit = 1'b1;
                  else clock_digits.hour = clock_digits.hour - 4'd1;
               end else begin
                  if (clock_digits.hour >= bstc_pkg::DIGIT_MAX) r.limit_hit = 1'b1;
                  else clock_digits.hour = clock_digits.hour + 4'd1;
               end
            end else if (step_minutes(step) != 0) begin
               n = step_minutes(step);
               m = minutes_of(clock_digits);
               if (dir == DIR_DOWN) begin
                  if (m < n) begin
                     m = 0;
                     r.limit_hit = 1'b1;
                  end else begin
                     m = m - n;
                  end
               end else begin
                  if (m + n > MINUTES_CEIL) begin
                     m = MINUTES_CEIL;
                     r.limit_hit = 1'b1;
                  end else begin
                     m = m + n;
                  end
               end
               clock_digits = time_from_tenths(m * 600);
            end
         end
         bstc_pkg::OP_CLEAR: clock_digits = '0;
         default: ;
      endcase
      r.shown  = display_of(clock_digits);
      r.digits = clock_digits;
      expected_displays.push_back(r);
   endtask

   // ---------------- request side ----------------

   // call right after a rising edge; returns at the edge where the transaction is taken
   task automatic issue_command(logic [1:0] op, logic dir, logic [2:0] step);
      if (idle_en && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_direction <= dir;
      req_step_size <= step;
      do @(posedge clock); while (req_stall);
      predict_display(op, dir, step);
      commands_sent++;
   endtask

   task automatic random_command();
      int         pick;
      int         run;
      logic       dir;
      logic [2:0] step;
      pick = $urandom_range(0, 19);
      dir  = 1'($urandom_range(0, 1));
      step = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      if (pick < 9) begin
         // runs of ticks in one direction so carries and borrows ripple
         run = $urandom_range(1, 25);
         repeat (run) issue_command(bstc_pkg::OP_TICK, dir, 3'($urandom_range(0, 7)));
      end else if (pick < 17) begin
         issue_command(bstc_pkg::OP_ADJUST, dir, step);
      end else if (pick == 17) begin
         issue_command(bstc_pkg::OP_CLEAR, dir, step);
      end else begin
         issue_command((pick == 18) ? OP_UNUSED : bstc_pkg::OP_TICK, dir, step);
      end
   endtask

   // ---------------- tests ----------------

   task automatic test_directed();
      issue_command(bstc_pkg::OP_TICK, DIR_DOWN, bstc_pkg::STEP_HOUR);   // tick down at zero
      issue_command(bstc_pkg::OP_TICK, DIR_UP, STEP_SPARE_HI);
      issue_command(OP_UNUSED, DIR_DOWN, STEP_SPARE_HI);
      issue_command(bstc_pkg::OP_ADJUST, DIR_UP, STEP_SPARE_LO);         // only clears seconds
      issue_command(bstc_pkg::OP_ADJUST, DIR_DOWN, STEP_SPARE_LO + 3'd1);
      issue_command(bstc_pkg::OP_ADJUST, DIR_DOWN, bstc_pkg::STEP_HOUR); // hour floor
      issue_command(bstc_pkg::OP_ADJUST, DIR_DOWN, bstc_pkg::STEP_MIN1); // minute floor
      issue_command(bstc_pkg::OP_ADJUST, DIR_UP, bstc_pkg::STEP_MIN5);
      issue_command(bstc_pkg::OP_TICK, DIR_DOWN, bstc_pkg::STEP_MIN5);   // borrow into minute ones
      issue_command(bstc_pkg::OP_ADJUST, DIR_DOWN, bstc_pkg::STEP_MIN10); // clamp at zero
      issue_command(bstc_pkg::OP_ADJUST, DIR_UP, bstc_pkg::STEP_MIN30);
      issue_command(bstc_pkg::OP_ADJUST, DIR_DOWN, bstc_pkg::STEP_MIN30); // lands on zero
      issue_command(bstc_pkg::OP_TICK, DIR_UP, bstc_pkg::STEP_HOUR);
      issue_command(bstc_pkg::OP_CLEAR, DIR_DOWN, STEP_SPARE_HI);
      repeat (9) issue_command(bstc_pkg::OP_ADJUST, DIR_UP, bstc_pkg::STEP_HOUR);
      issue_command(bstc_pkg::OP_ADJUST, DIR_UP, bstc_pkg::STEP_HOUR);   // hour ceiling
      issue_command(bstc_pkg::OP_ADJUST, DIR_UP, bstc_pkg::STEP_MIN30);
      issue_command(bstc_pkg::OP_ADJUST, DIR_UP, bstc_pkg::STEP_MIN30);  // clamp at 9:59
      issue_command(bstc_pkg::OP_ADJUST, DIR_DOWN, bstc_pkg::STEP_MIN5);
      issue_command(bstc_pkg::OP_ADJUST, DIR_UP, bstc_pkg::STEP_MIN5);   // lands on 9:59
   endtask

   task automatic test_tick_ceiling();
      issue_command(bstc_pkg::OP_CLEAR, DIR_UP, bstc_pkg::STEP_HOUR);
      repeat (9) issue_command(bstc_pkg::OP_ADJUST, DIR_UP, bstc_pkg::STEP_HOUR);
      repeat (2) issue_command(bstc_pkg::OP_ADJUST, DIR_UP, bstc_pkg::STEP_MIN30);
      // 599 ticks reach 9:59:59.9, the rest must saturate
      repeat (601) issue_command(bstc_pkg::OP_TICK, DIR_UP, bstc_pkg::STEP_HOUR);
      issue_command(bstc_pkg::OP_TICK, DIR_DOWN, bstc_pkg::STEP_HOUR);
      issue_command(bstc_pkg::OP_TICK, DIR_UP, bstc_pkg::STEP_HOUR);
      issue_command(bstc_pkg::OP_ADJUST, DIR_UP, bstc_pkg::STEP_MIN1);
   endtask

   task automatic test_random_walk();
      while (commands_sent < 1090) random_command();
   endtask

   task automatic test_no_idle();
      idle_en <= 1'b0;
      while (commands_sent < 1160) random_command();
   endtask

   // ---------------- result side ----------------

   task automatic check_field(string label, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
         $display("%0t %s: expected %0d, got %0d", $time, label, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      display_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_displays.size() == 0) begin
            $display("%0t unexpected transaction: expected none, got hours %0d", $time,
                     rsp_hours_now);
            error_count++;
         end else begin
            e = expected_displays.pop_front();
            check_field("limit_hit", 4'(e.limit_hit), 4'(rsp_limit_hit));
            check_field("shown_digit_low", e.shown.lo, rsp_shown_digit_low);
            check_field("shown_digit_mid", e.shown.mid, rsp_shown_digit_mid);
            check_field("shown_digit_high", e.shown.hi, rsp_shown_digit_high);
            check_field("dot_mask", 4'(e.shown.dots), 4'(rsp_dot_mask));
            check_field("hours_now", e.digits.hour, rsp_hours_now);
            check_field("minute_tens_now", 4'(e.digits.min_tens), 4'(rsp_minute_tens_now));
            check_field("minute_ones_now", e.digits.min_ones, rsp_minute_ones_now);
            check_field("second_tens_now", 4'(e.digits.sec_tens), 4'(rsp_second_tens_now));
            check_field("second_ones_now", e.digits.sec_ones, rsp_second_ones_now);
            check_field("tenths_now", e.digits.tenth, rsp_tenths_now);
         end
      end
   end

   // random stall bursts on the result side
   always @(posedge clock) begin
      if (reset || !idle_en) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_tick_ceiling();
      test_random_walk();
      test_no_idle();
      req_valid <= 1'b0;
      while (expected_displays.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
